// ----- design/urm_pkg.sv -----
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants for the 8250-style UART register model.
// ----------------------------------------------------------------------------
package urm_pkg;

	// Operation codes carried by each input word
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RECV  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// Register offsets from the port base
	typedef enum logic [2:0] {
		REG_DATA = 3'd0,
		REG_IER  = 3'd1,
		REG_IIR  = 3'd2,
		REG_LCR  = 3'd3,
		REG_MCR  = 3'd4,
		REG_LSR  = 3'd5,
		REG_MSR  = 3'd6,
		REG_SCR  = 3'd7
	} reg_sel_t;

	// Receive phase codes; the fourth code behaves as idle
	typedef enum logic [1:0] {
		RX_IDLE   = 2'd0,
		RX_WAIT   = 2'd1,
		RX_POPPED = 2'd2,
		RX_SPARE  = 2'd3
	} rx_phase_t;

	// Reset values
	localparam logic [2:0] IIR_NONE     = 3'b001;
	localparam logic [2:0] IIR_RX_DATA  = 3'b100;
	localparam logic [7:0] LCR_RESET    = 8'h03;
	localparam logic [7:0] LSR_RESET    = 8'h60;

	// Bit masks
	localparam int         LCR_DLAB_BIT = 7;
	localparam int         MCR_LOOP_BIT = 4;
	localparam logic [7:0] LSR_CLR_DR   = 8'b1111_1110;
	localparam logic [7:0] LSR_CLR_ERR  = 8'b1110_0001;
	localparam logic [7:0] LSR_CLR_THRE = 8'b1001_1111;
	localparam logic [7:0] LSR_THRE     = 8'b0110_0000;
	localparam logic [7:0] LSR_DR       = 8'b0000_0001;
	localparam logic [7:0] LSR_OE       = 8'b0000_0010;
	localparam logic [2:0] IIR_TX_SET   = 3'b010;
	localparam logic [2:0] IIR_TX_KEEP  = 3'b110;

	// Command queue sizing
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// Classified command passed from front to back
	typedef struct packed {
		op_t        op;
		reg_sel_t   sel;
		logic [7:0] data;
		logic       cts;
		logic [7:0] pms;
	} cmd_t;

endpackage

// ----- design/urm_if.sv -----
// ----------------------------------------------------------------------------
// urm_if
// Request and response channel interfaces of the UART register model.
// ----------------------------------------------------------------------------
interface urm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [2:0] reg_offset;
	logic [7:0] wr_data;
	logic [7:0] rx_byte;
	logic       peer_cts;
	logic [7:0] peer_modem_status;

	modport source (output valid, op, reg_offset, wr_data, rx_byte, peer_cts,
		peer_modem_status, input ready);
	modport sink (input valid, op, reg_offset, wr_data, rx_byte, peer_cts,
		peer_modem_status, output ready);
endinterface

interface urm_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rd_data;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       irq_request;
	logic       loop_active;

	modport source (output valid, rd_data, tx_valid, tx_byte, irq_request,
		loop_active, input ready);
	modport sink (input valid, rd_data, tx_valid, tx_byte, irq_request,
		loop_active, output ready);
endinterface

// ----- design/urm_front.sv -----
// ----------------------------------------------------------------------------
// urm_front
// Accepts request words, classifies them into commands and feeds the queue.
// ----------------------------------------------------------------------------
module urm_front
	import urm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	urm_req_if.sink       req,
	output logic          push_valid,
	input  logic          push_ready,
	output cmd_t          push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_in;
	op_t  op_in;

	// Classify: select the byte operand by operation
	always_comb begin
		op_in         = op_t'(req.op);
		cmd_in.op     = op_in;
		cmd_in.sel    = reg_sel_t'(req.reg_offset);
		cmd_in.data   = (op_in == OP_RECV) ? req.rx_byte : req.wr_data;
		cmd_in.cts    = req.peer_cts;
		cmd_in.pms    = req.peer_modem_status;
	end

	// Take a new word whenever the stage is empty or drains this cycle
	assign req.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the classified command
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

// ----- design/urm_queue.sv -----
// ----------------------------------------------------------------------------
// urm_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module urm_queue
	import urm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- design/urm_back.sv -----
// ----------------------------------------------------------------------------
// urm_back
// Executes commands on the UART register file and registers the response.
// ----------------------------------------------------------------------------
module urm_back
	import urm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  cmd_t     pop_cmd,
	urm_rsp_if.source rsp
);

	// Register file
	logic [7:0]  data_q;
	logic [15:0] div_q;
	logic [3:0]  ier_q;
	logic [2:0]  iir_q;
	logic [7:0]  lcr_q;
	logic [4:0]  mcr_q;
	logic [7:0]  lsr_q;
	logic        tx_phase_q;
	rx_phase_t   rx_phase_q;

	// Response register
	logic        rsp_valid_q;
	logic [7:0]  rd_data_q;
	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;
	logic        irq_q;
	logic        loop_q;

	// Next state
	logic [7:0]  data_n;
	logic [15:0] div_n;
	logic [3:0]  ier_n;
	logic [2:0]  iir_n;
	logic [7:0]  lcr_n;
	logic [4:0]  mcr_n;
	logic [7:0]  lsr_n;
	logic        tx_phase_n;
	rx_phase_t   rx_phase_n;
	logic [7:0]  rd_data_n;
	logic        tx_valid_n;
	logic [7:0]  tx_byte_n;
	logic        irq_n;
	logic        fire;
	logic        dlab;
	logic        loop_on;
	logic        rx_ok;

	assign pop_ready = !rsp_valid_q || rsp.ready;
	assign fire      = pop_valid && pop_ready;
	assign dlab      = lcr_q[LCR_DLAB_BIT];
	assign loop_on   = mcr_q[MCR_LOOP_BIT];
	assign rx_ok     = (mcr_q[1:0] == 2'b11) || loop_on;

	// Execute one command against the register file
	always_comb begin
		data_n     = data_q;
		div_n      = div_q;
		ier_n      = ier_q;
		iir_n      = iir_q;
		lcr_n      = lcr_q;
		mcr_n      = mcr_q;
		lsr_n      = lsr_q;
		tx_phase_n = tx_phase_q;
		rx_phase_n = rx_phase_q;
		rd_data_n  = 8'h00;
		tx_valid_n = 1'b0;
		tx_byte_n  = 8'h00;
		irq_n      = 1'b0;
		case (pop_cmd.op)
			OP_READ: begin
				case (pop_cmd.sel)
					REG_DATA: begin
						if (dlab) begin
							rd_data_n = div_q[7:0];
						end else begin
							rd_data_n  = data_q;
							lsr_n      = lsr_q & LSR_CLR_DR;
							iir_n      = IIR_NONE;
							rx_phase_n = RX_POPPED;
						end
					end
					REG_IER: rd_data_n = dlab ? div_q[15:8] : {4'h0, ier_q};
					REG_IIR: rd_data_n = {5'h00, iir_q};
					REG_LCR: rd_data_n = lcr_q;
					REG_MCR: rd_data_n = {3'h0, mcr_q};
					REG_LSR: begin
						rd_data_n = lsr_q;
						lsr_n     = lsr_q & LSR_CLR_ERR;
					end
					REG_MSR: rd_data_n = pop_cmd.pms;
					default: rd_data_n = 8'h00;
				endcase
			end
			OP_WRITE: begin
				case (pop_cmd.sel)
					REG_DATA: begin
						if (dlab) begin
							div_n[7:0] = pop_cmd.data;
						end else begin
							data_n     = pop_cmd.data;
							lsr_n      = lsr_q & LSR_CLR_THRE;
							tx_phase_n = 1'b1;
							// Loopback also receives the written word
							if (loop_on) begin
								lsr_n = lsr_n | LSR_DR;
								if (rx_phase_q == RX_WAIT) begin
									lsr_n = lsr_n | LSR_OE;
								end
								if (ier_q[0]) begin
									iir_n = IIR_RX_DATA;
								end
								rx_phase_n = RX_WAIT;
							end
						end
					end
					REG_IER: begin
						if (dlab) begin
							div_n[15:8] = pop_cmd.data;
						end else begin
							ier_n = pop_cmd.data[3:0];
						end
					end
					REG_LCR: lcr_n = pop_cmd.data;
					REG_MCR: mcr_n = pop_cmd.data[4:0];
					default: ;
				endcase
			end
			OP_RECV: begin
				if (rx_ok) begin
					data_n = pop_cmd.data;
					lsr_n  = lsr_q | LSR_DR;
					if (rx_phase_q == RX_WAIT) begin
						lsr_n = lsr_n | LSR_OE;
					end
					if (ier_q[0]) begin
						iir_n = IIR_RX_DATA;
					end
					rx_phase_n = RX_WAIT;
				end
			end
			OP_TICK: begin
				irq_n = !iir_q[0];
				// Complete a pending transmission
				if (tx_phase_q && (loop_on || pop_cmd.cts)) begin
					if (!loop_on) begin
						tx_valid_n = 1'b1;
						tx_byte_n  = data_q;
						data_n     = 8'h00;
					end
					lsr_n      = lsr_q | LSR_THRE;
					tx_phase_n = 1'b0;
					if (ier_q[1]) begin
						iir_n = (iir_q | IIR_TX_SET) & IIR_TX_KEEP;
					end
				end
				// Retire a word the host has read
				if (rx_phase_q == RX_POPPED) begin
					rx_phase_n = RX_IDLE;
				end
			end
			default: ;
		endcase
	end

	// Update register file on each executed command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q     <= 8'h00;
			div_q      <= 16'h0000;
			ier_q      <= 4'h0;
			iir_q      <= IIR_NONE;
			lcr_q      <= LCR_RESET;
			mcr_q      <= 5'h00;
			lsr_q      <= LSR_RESET;
			tx_phase_q <= 1'b0;
			rx_phase_q <= RX_IDLE;
		end else if (fire) begin
			data_q     <= data_n;
			div_q      <= div_n;
			ier_q      <= ier_n;
			iir_q      <= iir_n;
			lcr_q      <= lcr_n;
			mcr_q      <= mcr_n;
			lsr_q      <= lsr_n;
			tx_phase_q <= tx_phase_n;
			rx_phase_q <= rx_phase_n;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_data_q  <= rd_data_n;
			tx_valid_q <= tx_valid_n;
			tx_byte_q  <= tx_byte_n;
			irq_q      <= irq_n;
			loop_q     <= loop_on;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.rd_data     = rd_data_q;
	assign rsp.tx_valid    = tx_valid_q;
	assign rsp.tx_byte     = tx_byte_q;
	assign rsp.irq_request = irq_q;
	assign rsp.loop_active = loop_q;

endmodule

// ----- design/uart_register_model_top.sv -----
// Path: a request word passes the front stage, the queue and the response register.
// Throughput: one word per cycle while rsp.ready is high; the register file executes
// one command per cycle, only while the response register is empty or being taken.
// Reset: arst_n clears the queue and loads the 8250 defaults (LCR 0x03, LSR 0x60,
// IIR 0x01, all others zero) at once; no clearing pass.
// ----------------------------------------------------------------------------
// uart_register_model_top
// 8250-style UART register model: front classifier, command queue, executor.
// ----------------------------------------------------------------------------
module uart_register_model_top
	import urm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	urm_req_if.sink   req,
	urm_rsp_if.source rsp
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	urm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	urm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	urm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.rsp       (rsp)
	);

endmodule
